// ----- hw/rtl/pfe_pkg.sv -----
// Package for the postfix expression evaluator: beat types, codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package pfe_pkg;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic [2:0]         status;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OVERFLOW  = 3'd1,
        ST_UNDERFLOW = 3'd2,
        ST_LEFTOVER  = 3'd3,
        ST_DIVZERO   = 3'd4,
        ST_BADEXP    = 3'd5,
        ST_BADOP     = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POW  = 3'd5,
        OP_BAD  = 3'd6
    } t_op;

    // Classified command passed from front to back.
    typedef struct packed {
        t_op                op;
        logic signed [31:0] imm;
        logic               last;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_POP1, S_POP2, S_WAIT2, S_EXEC, S_MULW, S_DIVI, S_POWI, S_PUSH,
        S_FPOP, S_FWAIT, S_EMIT
    } t_state;

    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_CARET = 8'd94;
    localparam logic [7:0] CH_DOLL  = 8'd36;
    localparam logic [7:0] CH_LPAR  = 8'd40;
    localparam logic [7:0] CH_RPAR  = 8'd41;
    localparam logic [7:0] CH_ZERO  = 8'd48;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -66'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

endpackage

// ----- hw/rtl/postfix_expression_evaluator.sv -----
// Postfix evaluator, Q16.16. Push, + -, * (product, then scale), / (64-step restoring
// divider) and power (shared multiplier, n <= MAX_EXPONENT) run in the sequencer;
// a last beat then passes FPOP, FWAIT and EMIT before its result shows on the output.
// Throughput is one item at a time through the back-end sequencer; a two-entry
// command queue lets the front keep accepting while the back works.
// Reset: synchronous active-low; clears stack count, error flag, queue and result valid.
`timescale 1ns / 1ps
module postfix_expression_evaluator import pfe_pkg::*; #(
    parameter int STACK_DEPTH  = 32,
    parameter int MAX_EXPONENT = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_beat  i_in,
    output logic      empty,
    input  logic      pop,
    output t_out_beat o_out
);
    logic w_avail, w_take, w_rv;
    t_cmd w_cmd;

    // front: classify each beat
    pfe_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_in, .o_full(full),
        .i_take(w_take), .o_avail(w_avail), .o_cmd(w_cmd)
    );

    // back: stack and arithmetic; result register doubles as output queue
    pfe_back #(.STACK_DEPTH(STACK_DEPTH), .MAX_EXPONENT(MAX_EXPONENT)) u_back (
        .i_clk, .i_rst_n, .i_avail(w_avail), .i_cmd(w_cmd), .o_take(w_take),
        .o_res_valid(w_rv), .o_res(o_out), .i_res_take(pop)
    );

    assign empty = !w_rv;
endmodule

// ----- hw/rtl/pfe_front.sv -----
// Front end: classifies characters into commands and feeds a short queue.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
module pfe_front import pfe_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_beat i_in,
    output logic     o_full,
    input  logic     i_take,
    output logic     o_avail,
    output t_cmd     o_cmd
);
    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       w_wr, w_rd;

    always_comb begin
        n_cmd.last = i_in.last;
        n_cmd.imm  = '0;
        case (i_in.symbol)
            CH_PLUS:            n_cmd.op = OP_ADD;
            CH_MINUS:           n_cmd.op = OP_SUB;
            CH_STAR:            n_cmd.op = OP_MUL;
            CH_SLASH:           n_cmd.op = OP_DIV;
            CH_CARET, CH_DOLL:  n_cmd.op = OP_POW;
            CH_LPAR, CH_RPAR:   n_cmd.op = OP_BAD;
            default: begin
                n_cmd.op  = OP_PUSH;
                n_cmd.imm = (32'(signed'({1'b0, i_in.symbol})) - 32'sd48) <<< 16;
            end
        endcase
    end

    assign o_full  = (r_cnt == 2'(QD));
    assign o_avail = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_q[r_wp] <= n_cmd;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end
endmodule

// ----- hw/rtl/pfe_back.sv -----
// Back end: operand stack in memory, sequencer, shared multiplier, restoring divider.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
module pfe_back import pfe_pkg::*; #(
    parameter int STACK_DEPTH  = 32,
    parameter int MAX_EXPONENT = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_avail,
    input  t_cmd      i_cmd,
    output logic      o_take,
    output logic      o_res_valid,
    output t_out_beat o_res,
    input  logic      i_res_take
);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic signed [31:0] r_mem [STACK_DEPTH];
    logic signed [31:0] r_rd;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [2:0]         r_err, n_err;
    t_state             r_st, n_st;
    t_cmd               r_cmd, n_cmdr;
    logic signed [31:0] r_a, n_a, r_b, n_b, r_res, n_res;
    logic [5:0]         r_it, n_it;
    logic [63:0]        r_num, n_num;   // dividend magnitude / running quotient / product
    logic [32:0]        r_rem, n_rem;
    logic [31:0]        r_den, n_den;
    logic               r_neg, n_neg;
    logic               r_ov, n_ov;
    t_out_beat          r_out, n_out;
    logic               r_ov_valid, n_ov_valid;
    logic               w_re, w_we;
    logic [AW-1:0]      w_ra, w_wa;
    logic signed [31:0] w_wd;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_pq;
    logic [33:0]        w_sub;

    assign w_prod = r_a * r_b;
    // truncate toward zero on /2^16
    assign w_pq = (r_num[63] && (r_num[15:0] != 16'd0))
                  ? 66'(signed'(r_num[63:16])) + 66'sd1
                  : 66'(signed'(r_num[63:16]));
    assign w_sub = {r_rem[32:0], r_num[63]} - {2'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        if (w_re) r_rd <= r_mem[w_ra];
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE:  if (i_avail) n_st = (i_cmd.op == OP_PUSH) ? S_PUSH : S_POP1;
            S_POP1:  n_st = S_POP2;
            S_POP2:  n_st = S_WAIT2;
            S_WAIT2: n_st = S_EXEC;
            S_EXEC: begin
                case (r_cmd.op)
                    OP_MUL:  n_st = S_MULW;
                    OP_DIV:  n_st = (r_b == 0) ? S_PUSH : S_DIVI;
                    OP_POW:  n_st = S_POWI;
                    default: n_st = S_PUSH;
                endcase
            end
            S_MULW:  n_st = S_PUSH;
            S_DIVI:  if (r_it == 6'd63) n_st = S_PUSH;
            S_POWI:  if (r_it == 6'd0) n_st = S_PUSH;
            S_PUSH:  n_st = r_cmd.last ? S_FPOP : S_IDLE;
            S_FPOP:  n_st = S_FWAIT;
            S_FWAIT: n_st = S_EMIT;
            S_EMIT:  if (!r_ov_valid || i_res_take) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt; n_err = r_err; n_cmdr = r_cmd; n_a = r_a; n_b = r_b;
        n_res = r_res; n_it = r_it; n_num = r_num; n_rem = r_rem; n_den = r_den;
        n_neg = r_neg; n_ov = r_ov; n_out = r_out; n_ov_valid = r_ov_valid;
        o_take = 1'b0; w_re = 1'b0; w_we = 1'b0;
        w_ra = '0; w_wa = AW'(r_cnt); w_wd = r_res;
        if (i_res_take) n_ov_valid = 1'b0;
        case (r_st)
            S_IDLE: if (i_avail) begin
                o_take = 1'b1; n_cmdr = i_cmd; n_res = i_cmd.imm;
            end
            S_POP1, S_POP2: begin
                // pop: underflow reads zero
                if (r_cnt == '0) begin
                    if (n_err == ST_OK) n_err = ST_UNDERFLOW;
                    if (r_st == S_POP1) n_b = '0; else n_a = '0;
                    if (r_st == S_POP1) n_ov = 1'b1; else n_neg = 1'b1;
                end else begin
                    w_re = 1'b1; w_ra = AW'(r_cnt - 1'b1); n_cnt = r_cnt - 1'b1;
                    if (r_st == S_POP1) n_ov = 1'b0; else n_neg = 1'b0;
                end
                if (r_st == S_POP2 && !r_ov) n_b = r_rd;
            end
            S_WAIT2: begin
                if (!r_neg) n_a = r_rd;
            end
            S_EXEC: begin
                case (r_cmd.op)
                    OP_ADD: n_res = sat32(66'(r_a) + 66'(r_b));
                    OP_SUB: n_res = sat32(66'(r_a) - 66'(r_b));
                    OP_MUL: ;
                    OP_DIV: begin
                        if (r_b == 0) begin
                            n_res = '0;
                            if (n_err == ST_OK) n_err = ST_DIVZERO;
                        end else begin
                            n_neg = r_a[31] ^ r_b[31];
                            n_num = {16'd0, (r_a[31] ? 32'(-r_a) : 32'(r_a)), 16'd0};
                            n_den = r_b[31] ? 32'(-r_b) : 32'(r_b);
                            n_rem = '0; n_it = '0;
                        end
                    end
                    OP_POW: begin
                        n_res = Q_ONE;
                        if (r_b[31] || (r_b[31:16] > 16'(MAX_EXPONENT))) begin
                            n_res = '0; n_it = '0;
                            if (n_err == ST_OK) n_err = ST_BADEXP;
                        end else begin
                            n_it = 6'(r_b[31:16]);
                        end
                        n_a = Q_ONE;
                        n_b = r_a;  // base kept in r_b
                    end
                    default: begin
                        n_res = '0;
                        if (n_err == ST_OK) n_err = ST_BADOP;
                    end
                endcase
                n_num = (r_cmd.op == OP_DIV) ? n_num : 64'(w_prod);
            end
            S_MULW: n_res = sat32(w_pq);
            S_DIVI: begin
                // restoring division, one quotient bit per cycle
                n_it = r_it + 6'd1;
                if (!w_sub[33]) n_rem = w_sub[32:0];
                else n_rem = {r_rem[31:0], r_num[63]};
                n_num = {r_num[62:0], ~w_sub[33]};
                if (r_it == 6'd63) begin
                    n_res = r_neg ? sat32(-66'({2'b0, n_num})) : sat32(66'({2'b0, n_num}));
                end
            end
            S_POWI: begin
                // each multiply first registers the product in r_num, then scales it into r_a
                if (r_it != 6'd0) begin
                    if (r_ov) begin
                        n_a = sat32(w_pq); n_res = n_a; n_it = r_it - 6'd1; n_ov = 1'b0;
                    end else begin
                        n_num = 64'(w_prod); n_ov = 1'b1;
                    end
                end else n_res = (r_err == ST_BADEXP && r_res == '0) ? r_res : r_res;
            end
            S_PUSH: begin
                n_ov = 1'b0; n_neg = 1'b0;
                if (r_cnt >= CW'(STACK_DEPTH)) begin
                    if (n_err == ST_OK) n_err = ST_OVERFLOW;
                end else begin
                    w_we = 1'b1; n_cnt = r_cnt + 1'b1;
                end
            end
            S_FPOP: begin
                if (r_cnt == '0) begin
                    if (n_err == ST_OK) n_err = ST_UNDERFLOW;
                end else begin
                    w_re = 1'b1; w_ra = AW'(r_cnt - 1'b1); n_cnt = r_cnt - 1'b1;
                end
            end
            S_EMIT: if (!r_ov_valid || i_res_take) begin
                // waits here while the previous result is still unread
                n_out.status = r_err;
                if (r_err == ST_OK && r_cnt != '0) n_out.status = ST_LEFTOVER;
                n_out.value = (n_out.status == ST_OK) ? r_rd : '0;
                n_ov_valid = 1'b1; n_cnt = '0; n_err = ST_OK;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmdr; r_a <= n_a; r_res <= n_res; r_num <= n_num;
        r_rem <= n_rem; r_den <= n_den; r_out <= n_out; r_it <= n_it;
        r_b <= n_b;
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_err <= ST_OK; r_ov_valid <= 1'b0;
            r_neg <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_err <= n_err; r_ov_valid <= n_ov_valid;
            r_neg <= n_neg; r_ov <= n_ov;
        end
    end

    assign o_res_valid = r_ov_valid;
    assign o_res       = r_out;
endmodule

// ----- hw/rtl/pfe_checker.sv -----
// Port-level checker for the postfix evaluator, bound to the top level.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
module pfe_checker import pfe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      full,
    input logic      empty,
    input logic      pop,
    input t_out_beat o_out
);
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out.status <= ST_BADOP) else $error("bad status");
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.status != ST_OK) |-> o_out.value == 0) else $error("value");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out))) else $error("hold");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> (empty && !full))
        else $error("reset");
endmodule

bind postfix_expression_evaluator pfe_checker u_chk (
    .i_clk, .i_rst_n, .full, .empty, .pop, .o_out
);
